@@ src/skvt_pkg.sv @@
package skvt_pkg;

   localparam int MAX_ENTRIES_DEF = 16;
   localparam int KEY_W           = 8;
   localparam int VAL_W           = 32;
   localparam int POS_W           = 5;
   localparam int ACT_W           = 2;
   localparam int STS_W           = 2;

   typedef enum logic [ACT_W-1:0] {
      ACT_CLEAR  = 2'd0,
      ACT_APPEND = 2'd1,
      ACT_SORT   = 2'd2,
      ACT_LOOKUP = 2'd3
   } action_type;

   typedef enum logic [STS_W-1:0] {
      STS_OK   = 2'd0,
      STS_FULL = 2'd1,
      STS_DUP  = 2'd2
   } status_type;

   // controller to cells
   typedef struct packed {
      logic run;
      logic fwd;
      logic seed;
      logic wr_en;
   } cell_ctl_type;

   // cells back to controller
   typedef struct packed {
      logic swap_any;
      logic dup_any;
   } cell_sts_type;

endpackage

@@ src/skvt_cell.sv @@
module skvt_cell #(
   parameter int IDX_W = 4,
   parameter int IDX   = 0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  skvt_pkg::cell_ctl_type        ctl,
   input  logic [IDX_W-1:0]              seed_idx,
   input  logic [IDX_W-1:0]              wr_idx,
   input  logic [IDX_W-1:0]              rd_idx,
   input  logic [skvt_pkg::KEY_W-1:0]    wr_key,
   input  logic signed [skvt_pkg::VAL_W-1:0] wr_value,
   input  logic [skvt_pkg::KEY_W-1:0]    left_key,
   input  logic signed [skvt_pkg::VAL_W-1:0] left_value,
   input  logic                          left_tok,
   input  logic                          left_swap,
   input  logic [skvt_pkg::KEY_W-1:0]    right_key,
   input  logic signed [skvt_pkg::VAL_W-1:0] right_value,
   input  logic                          right_tok,
   output logic [skvt_pkg::KEY_W-1:0]    key,
   output logic signed [skvt_pkg::VAL_W-1:0] value,
   output logic                          tok,
   output logic                          swap_out,
   output logic                          dup_out,
   output logic [skvt_pkg::KEY_W-1:0]    rd_key,
   output logic signed [skvt_pkg::VAL_W-1:0] rd_value
);
   import skvt_pkg::*;

   logic [KEY_W-1:0]        key_ff, key_in;
   logic signed [VAL_W-1:0] value_ff, value_in;
   logic                    tok_ff, tok_in;
   logic                    hit;
   logic                    swap_me;
   logic                    rd_sel;

   // this cell owns the pair (self, right neighbor) while it holds the token
   assign hit     = ctl.run & tok_ff;
   assign swap_me = hit & (key_ff > right_key);
   assign rd_sel  = (rd_idx == IDX_W'(IDX));

   always_comb begin
      key_in   = key_ff;
      value_in = value_ff;
      if (ctl.wr_en && (wr_idx == IDX_W'(IDX))) begin
         key_in   = wr_key;
         value_in = wr_value;
      end else if (swap_me) begin
         key_in   = right_key;
         value_in = right_value;
      end else if (left_swap) begin
         key_in   = left_key;
         value_in = left_value;
      end
   end

   always_comb begin
      if (ctl.seed) begin
         tok_in = (seed_idx == IDX_W'(IDX));
      end else if (ctl.run) begin
         tok_in = ctl.fwd ? left_tok : right_tok;
      end else begin
         tok_in = tok_ff;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= 1'b0;
      end else begin
         tok_ff <= tok_in;
      end
   end

   assign key      = key_ff;
   assign value    = value_ff;
   assign tok      = tok_ff;
   assign swap_out = swap_me;
   assign dup_out  = hit & (key_ff == right_key);
   assign rd_key   = rd_sel ? key_ff : '0;
   assign rd_value = rd_sel ? value_ff : '0;

endmodule

@@ src/skvt_ctrl.sv @@
module skvt_ctrl #(
   parameter int MAX_ENTRIES = skvt_pkg::MAX_ENTRIES_DEF,
   parameter int IDX_W       = $clog2(MAX_ENTRIES)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [skvt_pkg::ACT_W-1:0]        req_action,
   input  logic [skvt_pkg::KEY_W-1:0]        req_key,
   input  logic signed [skvt_pkg::VAL_W-1:0] req_default_value,
   input  skvt_pkg::cell_sts_type            sts,
   input  logic [skvt_pkg::KEY_W-1:0]        rd_key,
   input  logic signed [skvt_pkg::VAL_W-1:0] rd_value,
   output skvt_pkg::cell_ctl_type            ctl,
   output logic [IDX_W-1:0]                  seed_idx,
   output logic [IDX_W-1:0]                  wr_idx,
   output logic [IDX_W-1:0]                  rd_idx,
   output logic                              rsp_valid,
   output logic [skvt_pkg::STS_W-1:0]        rsp_status,
   output logic                              rsp_found,
   output logic [skvt_pkg::POS_W-1:0]        rsp_position,
   output logic signed [skvt_pkg::VAL_W-1:0] rsp_result_value
);
   import skvt_pkg::*;

   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SEED   = 5'b00010,
      ST_PASS   = 5'b00100,
      ST_LK_MID = 5'b01000,
      ST_LK_CMP = 5'b10000
   } state_type;

   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [CNT_W-1:0]        lo_ff, lo_in;
   logic [CNT_W-1:0]        hi_ff, hi_in;
   logic [IDX_W-1:0]        p_ff, p_in;
   logic [IDX_W-1:0]        mid_ff, mid_in;
   logic                    fwd_ff, fwd_in;
   logic                    moved_ff, moved_in;
   logic [KEY_W-1:0]        key_ff, key_in;
   logic signed [VAL_W-1:0] dflt_ff, dflt_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   status_type              rsp_status_ff, rsp_status_in;
   logic                    rsp_found_ff, rsp_found_in;
   logic [POS_W-1:0]        rsp_position_ff, rsp_position_in;
   logic signed [VAL_W-1:0] rsp_result_ff, rsp_result_in;

   logic [CNT_W-1:0]        hi_m1;
   logic [CNT_W:0]          mid_sum;
   logic                    moved_now;
   logic                    last_pair;
   logic [CNT_W-1:0]        next_lo;
   logic [CNT_W-1:0]        next_hi;

   assign hi_m1    = hi_ff - CNT_W'(1);
   assign mid_sum  = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign seed_idx = fwd_ff ? lo_ff[IDX_W-1:0] : hi_m1[IDX_W-1:0];
   assign wr_idx   = count_ff[IDX_W-1:0];
   assign rd_idx   = mid_ff;
   assign moved_now = moved_ff | sts.swap_any;
   assign last_pair = fwd_ff ? (CNT_W'(p_ff) == hi_m1) : (CNT_W'(p_ff) == lo_ff);
   assign next_lo  = fwd_ff ? lo_ff : lo_ff + CNT_W'(1);
   assign next_hi  = fwd_ff ? hi_m1 : hi_ff;

   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      lo_in           = lo_ff;
      hi_in           = hi_ff;
      p_in            = p_ff;
      mid_in          = mid_ff;
      fwd_in          = fwd_ff;
      moved_in        = moved_ff;
      key_in          = key_ff;
      dflt_in         = dflt_ff;
      rsp_valid_in    = 1'b0;
      rsp_status_in   = rsp_status_ff;
      rsp_found_in    = rsp_found_ff;
      rsp_position_in = rsp_position_ff;
      rsp_result_in   = rsp_result_ff;
      ctl             = '0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               rsp_status_in   = STS_OK;
               rsp_found_in    = 1'b0;
               rsp_position_in = '0;
               rsp_result_in   = '0;
               case (action_type'(req_action))
                  ACT_CLEAR: begin
                     count_in     = '0;
                     rsp_valid_in = 1'b1;
                  end
                  ACT_APPEND: begin
                     rsp_valid_in = 1'b1;
                     if (count_ff >= CNT_W'(MAX_ENTRIES)) begin
                        rsp_status_in = STS_FULL;
                     end else begin
                        ctl.wr_en = 1'b1;
                        count_in  = count_ff + CNT_W'(1);
                     end
                  end
                  ACT_SORT: begin
                     if (count_ff < CNT_W'(2)) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        lo_in    = '0;
                        hi_in    = count_ff - CNT_W'(1);
                        fwd_in   = 1'b1;
                        state_in = ST_SEED;
                     end
                  end
                  ACT_LOOKUP: begin
                     lo_in    = '0;
                     hi_in    = count_ff;
                     key_in   = req_key;
                     dflt_in  = req_default_value;
                     state_in = ST_LK_MID;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end

         ST_SEED: begin
            // drop the token onto the first pair of this pass
            ctl.seed = 1'b1;
            p_in     = seed_idx;
            moved_in = 1'b0;
            state_in = ST_PASS;
         end

         ST_PASS: begin
            ctl.run  = 1'b1;
            ctl.fwd  = fwd_ff;
            moved_in = moved_now;
            if (sts.dup_any) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STS_DUP;
               state_in      = ST_IDLE;
            end else if (last_pair) begin
               if (!moved_now || !(next_lo < next_hi)) begin
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  lo_in    = next_lo;
                  hi_in    = next_hi;
                  fwd_in   = !fwd_ff;
                  state_in = ST_SEED;
               end
            end else begin
               p_in = fwd_ff ? p_ff + IDX_W'(1) : p_ff - IDX_W'(1);
            end
         end

         ST_LK_MID: begin
            if (lo_ff < hi_ff) begin
               mid_in   = IDX_W'(mid_sum >> 1);
               state_in = ST_LK_CMP;
            end else begin
               rsp_valid_in    = 1'b1;
               rsp_position_in = POS_W'(lo_ff);
               rsp_result_in   = dflt_ff;
               state_in        = ST_IDLE;
            end
         end

         ST_LK_CMP: begin
            if (key_ff < rd_key) begin
               hi_in    = CNT_W'(mid_ff);
               state_in = ST_LK_MID;
            end else if (key_ff > rd_key) begin
               lo_in    = CNT_W'(mid_ff) + CNT_W'(1);
               state_in = ST_LK_MID;
            end else begin
               rsp_valid_in    = 1'b1;
               rsp_found_in    = 1'b1;
               rsp_position_in = POS_W'(mid_ff);
               rsp_result_in   = rd_value;
               state_in        = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff           <= lo_in;
      hi_ff           <= hi_in;
      p_ff            <= p_in;
      mid_ff          <= mid_in;
      fwd_ff          <= fwd_in;
      moved_ff        <= moved_in;
      key_ff          <= key_in;
      dflt_ff         <= dflt_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_found_ff    <= rsp_found_in;
      rsp_position_ff <= rsp_position_in;
      rsp_result_ff   <= rsp_result_in;
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_position     = rsp_position_ff;
   assign rsp_result_value = rsp_result_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_ENTRIES))
      else $error("entry count above table size");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_action == ACT_CLEAR) |=> (rsp_valid && count_ff == '0))
      else $error("clear did not empty the table in one cycle");

   a_search_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LK_CMP) |->
         (lo_ff < hi_ff && CNT_W'(mid_ff) >= lo_ff && CNT_W'(mid_ff) < hi_ff))
      else $error("binary search probe outside its window");

   a_pass_in_table: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PASS) |-> (CNT_W'(p_ff) < count_ff - CNT_W'(1)))
      else $error("sort pair beyond the last entry");
`endif

endmodule

@@ src/sorted_key_value_table_core.sv @@
// sorted key/value table, up to MAX_ENTRIES entries held in a row of cells
//
// a request beat is taken when start is high and busy is low; req_action picks
// clear, append, sort or lookup. every request gives exactly one response beat:
// rsp_valid is high for one cycle with rsp_status, rsp_found, rsp_position and
// rsp_result_value. the receiver cannot stall, so it must take the beat then.
//
// clear and append answer one cycle after the request and busy stays low, so
// these can be issued every cycle. lookup is a binary search in which each probe
// forms the midpoint, then compares the key against the addressed cell.
// sort is a cocktail shaker sort done by a token that walks the cells, one
// compare-and-swap of neighbors per cycle, plus a seed step that places the
// token at the start of each pass; a sort ends early when a pass makes no
// swap or a duplicate key is met. busy is high for the whole of a lookup or of
// a sort of two or more entries.
//
// reset empties the table and raises no response beat.
module sorted_key_value_table_core #(
   parameter int MAX_ENTRIES = skvt_pkg::MAX_ENTRIES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [skvt_pkg::ACT_W-1:0]        req_action,
   input  logic [skvt_pkg::KEY_W-1:0]        req_key,
   input  logic signed [skvt_pkg::VAL_W-1:0] req_value,
   input  logic signed [skvt_pkg::VAL_W-1:0] req_default_value,
   output logic                              rsp_valid,
   output logic [skvt_pkg::STS_W-1:0]        rsp_status,
   output logic                              rsp_found,
   output logic [skvt_pkg::POS_W-1:0]        rsp_position,
   output logic signed [skvt_pkg::VAL_W-1:0] rsp_result_value
);
   import skvt_pkg::*;

   localparam int IDX_W = $clog2(MAX_ENTRIES);

   cell_ctl_type            ctl;
   cell_sts_type            sts;
   logic [IDX_W-1:0]        seed_idx;
   logic [IDX_W-1:0]        wr_idx;
   logic [IDX_W-1:0]        rd_idx;
   logic [KEY_W-1:0]        rd_key;
   logic signed [VAL_W-1:0] rd_value;

   logic [KEY_W-1:0]        cell_key[MAX_ENTRIES];
   logic signed [VAL_W-1:0] cell_value[MAX_ENTRIES];
   logic [KEY_W-1:0]        cell_rd_key[MAX_ENTRIES];
   logic signed [VAL_W-1:0] cell_rd_value[MAX_ENTRIES];
   logic [MAX_ENTRIES-1:0]  tok_vec;
   logic [MAX_ENTRIES-1:0]  swap_vec;
   logic [MAX_ENTRIES-1:0]  dup_vec;

   skvt_ctrl #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .IDX_W       (IDX_W)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_action        (req_action),
      .req_key           (req_key),
      .req_default_value (req_default_value),
      .sts               (sts),
      .rd_key            (rd_key),
      .rd_value          (rd_value),
      .ctl               (ctl),
      .seed_idx          (seed_idx),
      .wr_idx            (wr_idx),
      .rd_idx            (rd_idx),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_found         (rsp_found),
      .rsp_position      (rsp_position),
      .rsp_result_value  (rsp_result_value)
   );

   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      logic [KEY_W-1:0]        l_key;
      logic signed [VAL_W-1:0] l_value;
      logic                    l_tok;
      logic                    l_swap;
      logic [KEY_W-1:0]        r_key;
      logic signed [VAL_W-1:0] r_value;
      logic                    r_tok;

      if (i == 0) begin : g_left_edge
         assign l_key   = '0;
         assign l_value = '0;
         assign l_tok   = 1'b0;
         assign l_swap  = 1'b0;
      end else begin : g_left
         assign l_key   = cell_key[i-1];
         assign l_value = cell_value[i-1];
         assign l_tok   = tok_vec[i-1];
         assign l_swap  = swap_vec[i-1];
      end

      if (i == MAX_ENTRIES - 1) begin : g_right_edge
         assign r_key   = '0;
         assign r_value = '0;
         assign r_tok   = 1'b0;
      end else begin : g_right
         assign r_key   = cell_key[i+1];
         assign r_value = cell_value[i+1];
         assign r_tok   = tok_vec[i+1];
      end

      skvt_cell #(
         .IDX_W (IDX_W),
         .IDX   (i)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .seed_idx    (seed_idx),
         .wr_idx      (wr_idx),
         .rd_idx      (rd_idx),
         .wr_key      (req_key),
         .wr_value    (req_value),
         .left_key    (l_key),
         .left_value  (l_value),
         .left_tok    (l_tok),
         .left_swap   (l_swap),
         .right_key   (r_key),
         .right_value (r_value),
         .right_tok   (r_tok),
         .key         (cell_key[i]),
         .value       (cell_value[i]),
         .tok         (tok_vec[i]),
         .swap_out    (swap_vec[i]),
         .dup_out     (dup_vec[i]),
         .rd_key      (cell_rd_key[i]),
         .rd_value    (cell_rd_value[i])
      );
   end

   // only the addressed cell drives a nonzero read value
   always_comb begin
      rd_key   = '0;
      rd_value = '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         rd_key   = rd_key | cell_rd_key[i];
         rd_value = rd_value | cell_rd_value[i];
      end
   end

   assign sts.swap_any = |swap_vec;
   assign sts.dup_any  = |dup_vec;

`ifndef ASSERT_OFF
   a_single_token: assert property (@(posedge clock) disable iff (reset)
      $onehot0(tok_vec))
      else $error("more than one sort token in the cell row");

   a_token_on_run: assert property (@(posedge clock) disable iff (reset)
      ctl.run |-> $onehot(tok_vec))
      else $error("sort step with no token in the cell row");
`endif

endmodule
